// ----- hdl/hjs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hjs_pkg;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_W = 32;
    localparam int OCC_W  = 5;

    typedef logic [1:0] status_t;
    localparam status_t ST_INSERTED = 2'd0;
    localparam status_t ST_SELECTED = 2'd1;
    localparam status_t ST_EMPTY    = 2'd2;
    localparam status_t ST_FULL     = 2'd3;
endpackage
`default_nettype wire

// ----- hdl/hrrn_job_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | fields
// s_      | in        | action, job_arrival, job_service, now
// m_      | out       | status, chosen_arrival, chosen_service, occupancy
//
// insert, empty and full requests return a registered result from idle, back to back.
// a select with n waiting jobs scans each job in turn through the shared cross-multiply
// unit (S_MUL, then S_CMP), then makes one ring rotation to remove the chosen job.
// aresetn (synchronous) empties the table; stored times are not cleared.
// a held result that is not taken stalls every next request.
module hrrn_job_selector #(
    parameter int QUEUE_DEPTH = hjs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [hjs_pkg::TIME_W-1:0]    s_job_arrival,
    input  wire logic [hjs_pkg::TIME_W-1:0]    s_job_service,
    input  wire logic [hjs_pkg::TIME_W-1:0]    s_now,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output hjs_pkg::status_t                   m_status,
    output logic      [hjs_pkg::TIME_W-1:0]    m_chosen_arrival,
    output logic      [hjs_pkg::TIME_W-1:0]    m_chosen_service,
    output logic      [hjs_pkg::OCC_W-1:0]     m_occupancy
);
    import hjs_pkg::*;
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL    = 5'b00010,
        S_CMP    = 5'b00100,
        S_REMOVE = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg, n_reg, k_reg;
    logic [IW-1:0] best_idx_reg;
    logic [TIME_W-1:0] now_reg, best_wait_reg, best_svc_reg;
    logic [TIME_W-1:0] pick_arr_reg, pick_svc_reg;
    logic m_valid_reg;
    status_t m_status_reg;
    logic [TIME_W-1:0] m_arr_reg, m_svc_reg;
    logic [OCC_W-1:0] m_occ_reg;

    logic [TIME_W-1:0] cell_arr [QUEUE_DEPTH];
    logic [TIME_W-1:0] cell_svc [QUEUE_DEPTH];
    logic [TIME_W-1:0] head_wait;
    logic [2*TIME_W-1:0] cand_prod, best_prod;
    logic out_free, accept, ins_ok, shift_en, pop, do_pop, res_load;
    logic [IW-1:0] tail;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign ins_ok   = accept && !s_action && (count_reg < CW'(QUEUE_DEPTH));
    assign tail     = IW'(count_reg - CW'(1));
    assign head_wait = (now_reg >= cell_arr[0]) ? now_reg - cell_arr[0] : '0;
    assign do_pop   = (state_reg == S_REMOVE) && (IW'(k_reg) == best_idx_reg);
    assign pop      = do_pop;
    assign shift_en = (state_reg == S_CMP) || (state_reg == S_REMOVE);
    // a new result enters the output register this cycle
    assign res_load = (accept && (!s_action || (count_reg == '0)))
                      || ((state_reg == S_FINISH) && out_free);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic [TIME_W-1:0] nxt_arr, nxt_svc;
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign nxt_arr = '0;
                assign nxt_svc = '0;
            end else begin : g_mid
                assign nxt_arr = cell_arr[gi+1];
                assign nxt_svc = cell_svc[gi+1];
            end
            hjs_cell #(.QUEUE_DEPTH(QUEUE_DEPTH), .IDX(gi)) u_cell (
                .aclk        (aclk),
                .wr_en       (ins_ok && (count_reg == CW'(gi))),
                .wr_arrival  (s_job_arrival),
                .wr_service  (s_job_service),
                .shift_en    (shift_en),
                .pop         (pop),
                .tail        (tail),
                .next_arrival(nxt_arr),
                .next_service(nxt_svc),
                .head_arrival(cell_arr[0]),
                .head_service(cell_svc[0]),
                .arrival_reg (cell_arr[gi]),
                .service_reg (cell_svc[gi])
            );
        end
    endgenerate

    hjs_ratio_mul u_mul (
        .aclk         (aclk),
        .en           (state_reg == S_MUL),
        .cand_wait    (head_wait),
        .cand_service (cell_svc[0]),
        .best_wait    (best_wait_reg),
        .best_service (best_svc_reg),
        .cand_prod_reg(cand_prod),
        .best_prod_reg(best_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (res_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (!s_action) begin
                            m_arr_reg    <= '0;
                            m_svc_reg    <= '0;
                            if (ins_ok) begin
                                count_reg    <= count_reg + CW'(1);
                                m_status_reg <= ST_INSERTED;
                                m_occ_reg    <= OCC_W'(count_reg + CW'(1));
                            end else begin
                                m_status_reg <= ST_FULL;
                                m_occ_reg    <= OCC_W'(count_reg);
                            end
                        end else if (count_reg == '0) begin
                            m_arr_reg    <= '0;
                            m_svc_reg    <= '0;
                            m_status_reg <= ST_EMPTY;
                            m_occ_reg    <= '0;
                        end else begin
                            now_reg   <= s_now;
                            n_reg     <= count_reg;
                            k_reg     <= '0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: state_reg <= S_CMP;
                S_CMP: begin
                    // first entry seeds the best; strict compare keeps the earliest on ties
                    if (k_reg == '0 || cand_prod > best_prod) begin
                        best_idx_reg  <= IW'(k_reg);
                        best_wait_reg <= head_wait;
                        best_svc_reg  <= cell_svc[0];
                    end
                    if (k_reg == n_reg - CW'(1)) begin
                        k_reg     <= '0;
                        state_reg <= S_REMOVE;
                    end else begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_REMOVE: begin
                    if (do_pop) begin
                        pick_arr_reg <= cell_arr[0];
                        pick_svc_reg <= cell_svc[0];
                        count_reg    <= count_reg - CW'(1);
                    end
                    k_reg <= k_reg + CW'(1);
                    if (k_reg == n_reg - CW'(1)) state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_status_reg <= ST_SELECTED;
                        m_arr_reg    <= pick_arr_reg;
                        m_svc_reg    <= pick_svc_reg;
                        m_occ_reg    <= OCC_W'(count_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_chosen_arrival = m_arr_reg;
    assign m_chosen_service = m_svc_reg;
    assign m_occupancy      = m_occ_reg;
endmodule
`default_nettype wire

// ----- hdl/hjs_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hjs_cell #(
    parameter int QUEUE_DEPTH = hjs_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX = 0
) (
    input  wire logic                           aclk,
    input  wire logic                           wr_en,
    input  wire logic [hjs_pkg::TIME_W-1:0]     wr_arrival,
    input  wire logic [hjs_pkg::TIME_W-1:0]     wr_service,
    input  wire logic                           shift_en,
    input  wire logic                           pop,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0] tail,
    input  wire logic [hjs_pkg::TIME_W-1:0]     next_arrival,
    input  wire logic [hjs_pkg::TIME_W-1:0]     next_service,
    input  wire logic [hjs_pkg::TIME_W-1:0]     head_arrival,
    input  wire logic [hjs_pkg::TIME_W-1:0]     head_service,
    output logic      [hjs_pkg::TIME_W-1:0]     arrival_reg,
    output logic      [hjs_pkg::TIME_W-1:0]     service_reg
);
    import hjs_pkg::*;
    localparam int IW = $clog2(QUEUE_DEPTH);

    logic wrap;
    assign wrap = !pop && (tail == IW'(IDX));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            arrival_reg <= wr_arrival;
            service_reg <= wr_service;
        end else if (shift_en) begin
            // the tail cell closes the ring while rotating, except when the head is popped
            if (wrap) begin
                arrival_reg <= head_arrival;
                service_reg <= head_service;
            end else begin
                arrival_reg <= next_arrival;
                service_reg <= next_service;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/hjs_ratio_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hjs_ratio_mul (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [hjs_pkg::TIME_W-1:0]    cand_wait,
    input  wire logic [hjs_pkg::TIME_W-1:0]    cand_service,
    input  wire logic [hjs_pkg::TIME_W-1:0]    best_wait,
    input  wire logic [hjs_pkg::TIME_W-1:0]    best_service,
    output logic      [2*hjs_pkg::TIME_W-1:0]  cand_prod_reg,
    output logic      [2*hjs_pkg::TIME_W-1:0]  best_prod_reg
);
    import hjs_pkg::*;

    // cross products: candidate wins when wait_c * svc_b > wait_b * svc_c
    always_ff @(posedge aclk) begin
        if (en) begin
            cand_prod_reg <= (2*TIME_W)'(cand_wait) * (2*TIME_W)'(best_service);
            best_prod_reg <= (2*TIME_W)'(best_wait) * (2*TIME_W)'(cand_service);
        end
    end
endmodule
`default_nettype wire

// ----- hdl/hjs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hjs_checker #(
    parameter int QUEUE_DEPTH = hjs_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire hjs_pkg::status_t           m_status,
    input wire logic [hjs_pkg::TIME_W-1:0] m_chosen_arrival,
    input wire logic [hjs_pkg::TIME_W-1:0] m_chosen_service,
    input wire logic [hjs_pkg::OCC_W-1:0]  m_occupancy
);
    import hjs_pkg::*;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(CW'(QUEUE_DEPTH));

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_chosen_arrival) && $stable(m_occupancy))
        else $error("result changed while stalled");

    // a stalled result blocks new requests
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && m_valid && !m_ready |-> !s_ready)
        else $error("request taken while result stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_SELECTED |-> m_chosen_arrival == '0
            && m_chosen_service == '0)
        else $error("chosen fields nonzero without a selection");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_occupancy == '0)
        else $error("empty report with jobs waiting");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_occupancy == FULL_OCC)
        else $error("full report below depth");
endmodule

bind hrrn_job_selector hjs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_hjs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_chosen_arrival(m_chosen_arrival),
    .m_chosen_service(m_chosen_service),
    .m_occupancy     (m_occupancy)
);
`default_nettype wire
